// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted priority queue.
// No dependencies; every other file imports this package.
package spq_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } spq_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        entry_count;
    } spq_rsp_t;

    // Compare results each cell latches when a command is taken
    typedef struct packed {
        logic gt;   // occupied and larger than the command value
        logic eq;   // occupied and equal to the command value
        logic sel;  // occupied and addressed by the read position
    } spq_flags_t;

    // Update broadcast to every cell
    typedef struct packed {
        logic                      ins;
        logic                      del;
        logic signed [VALUE_W-1:0] value;
    } spq_ctrl_t;

endpackage

// File: rtl/spq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry, latches its compare flags,
// and shifts toward either neighbor on insert or delete. Uses spq_pkg.
module spq_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 7
) (
    input  logic                               clk,
    input  logic                               cmp_en,
    input  logic signed [spq_pkg::VALUE_W-1:0] cmp_value,
    input  logic [spq_pkg::POS_W-1:0]          cmp_position,
    input  logic [CW-1:0]                      count,
    input  spq_pkg::spq_ctrl_t                 ctrl,
    input  logic signed [spq_pkg::VALUE_W-1:0] prev_entry,
    input  logic                               prev_gt,
    input  logic signed [spq_pkg::VALUE_W-1:0] next_entry,
    output logic signed [spq_pkg::VALUE_W-1:0] entry,
    output spq_pkg::spq_flags_t                flags
);
    import spq_pkg::*;

    localparam logic ADDRESSABLE = (INDEX < (1 << POS_W));

    logic signed [VALUE_W-1:0] entry_reg;
    spq_flags_t                flags_reg;
    spq_flags_t                flags_next;
    logic                      occupied;
    logic                      pos_hit;

    assign occupied = (CW'(INDEX) < count);
    assign pos_hit  = ADDRESSABLE && (cmp_position == POS_W'(INDEX));

    always_comb
    begin
        flags_next.gt  = occupied && (entry_reg > cmp_value);
        flags_next.eq  = occupied && (entry_reg == cmp_value);
        flags_next.sel = occupied && pos_hit;
    end

    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            flags_reg <= flags_next;
        end
    end

    // Cells at or past the insertion point take from the left; the first
    // of them takes the new value. Delete pulls from the right.
    always_ff @(posedge clk)
    begin
        if (ctrl.ins && !flags_reg.gt)
        begin
            entry_reg <= prev_gt ? ctrl.value : prev_entry;
        end
        else if (ctrl.del && !flags_reg.gt)
        begin
            entry_reg <= next_entry;
        end
    end

    assign entry = entry_reg;
    assign flags = flags_reg;

endmodule

// File: rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Top level of the sorted priority queue: command handshake, count and
// response register around a chain of spq_cell slots. Uses spq_pkg.
//
// Each command is handled in two steps: when it transfers, every cell
// latches its compare against the command value and position; then, in the
// apply state, the chain shifts in one step and the response is loaded into
// the output register. The command port stalls while a command is in the
// apply state, so a new command cannot transfer until the current one is
// applied. A stalled response holds the apply state until the response
// register has room. The count resets to zero and the entries need no clearing.
module sorted_priority_queue #(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  spq_pkg::spq_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output spq_pkg::spq_rsp_t rsp
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t             state_reg, state_next;
    logic [CMD_W-1:0]   command_reg, command_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               rsp_valid_reg, rsp_valid_next;
    spq_rsp_t           rsp_reg, rsp_next;

    logic signed [VALUE_W-1:0] entry_w [DEPTH];
    spq_flags_t                flags_w [DEPTH];
    spq_ctrl_t                 ctrl;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      accept;
    logic                      fire;
    logic                      found;
    logic                      hit;
    logic signed [VALUE_W-1:0] rd_bus;
    logic [EW-1:0]             count_ext;

    assign cmd_stall = (state_reg == S_APPLY);
    assign accept    = cmd_valid && !cmd_stall;
    assign fire      = (state_reg == S_APPLY) && (!rsp_valid_reg || !rsp_stall);

    // Gather match and read flags from the whole chain
    always_comb
    begin
        found  = 1'b0;
        hit    = 1'b0;
        rd_bus = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            found  = found | flags_w[i].eq;
            hit    = hit | flags_w[i].sel;
            rd_bus = rd_bus | (entry_w[i] & {VALUE_W{flags_w[i].sel}});
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [VALUE_W-1:0] prev_entry;
            logic                      prev_gt;
            logic signed [VALUE_W-1:0] next_entry;

            if (g == 0)
            begin : g_head
                assign prev_entry = '0;
                assign prev_gt    = 1'b1;
            end
            else
            begin : g_body
                assign prev_entry = entry_w[g-1];
                assign prev_gt    = flags_w[g-1].gt;
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign next_entry = '0;
            end
            else
            begin : g_link
                assign next_entry = entry_w[g+1];
            end

            spq_cell #(
                .INDEX (g),
                .CW    (CW)
            ) u_cell (
                .clk          (clk),
                .cmp_en       (accept),
                .cmp_value    (cmd.value),
                .cmp_position (cmd.position),
                .count        (count_reg),
                .ctrl         (ctrl),
                .prev_entry   (prev_entry),
                .prev_gt      (prev_gt),
                .next_entry   (next_entry),
                .entry        (entry_w[g]),
                .flags        (flags_w[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= cmd.value;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        command_next   = command_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ctrl.ins       = 1'b0;
        ctrl.del       = 1'b0;
        ctrl.value     = value_reg;
        count_ext      = EW'(count_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    command_next = cmd.command;
                    state_next   = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (fire)
                begin
                    rsp_next.status     = ST_OK;
                    rsp_next.read_value = '0;
                    case (command_reg)
                        CMD_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                ctrl.ins   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else if (!found)
                            begin
                                rsp_next.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ctrl.del   = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            if (hit)
                            begin
                                rsp_next.read_value = rd_bus;
                            end
                            else
                            begin
                                rsp_next.status = ST_BAD_POS;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = ST_OK;
                        end
                    endcase
                    count_ext            = EW'(count_next);
                    rsp_next.entry_count = count_ext[COUNT_W-1:0];
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            command_reg   <= CMD_INSERT;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            command_reg   <= command_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue: a directed table, then
// phased random traffic, checked against an in-bench model of the sorted store.
// Depends on spq_pkg and the sorted_priority_queue RTL only.
module tb_top;
    import spq_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 630;
    localparam int CALM_ITEMS   = 60;
    localparam int QUIET_LIMIT  = 2000;

    localparam logic [CMD_W-1:0]          CMD_UNUSED = 2'd3;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN  = 32'sh8000_0000;

    typedef enum logic [1:0] {PHASE_MIXED, PHASE_FILL, PHASE_DRAIN} traffic_phase_t;

    typedef struct {
        spq_cmd_t op;
        bit       fixed;    // response typed in by hand
        spq_rsp_t rsp;
    } table_row_t;

    logic     clk;
    logic     rst_n;
    logic     cmd_valid;
    logic     cmd_stall;
    spq_cmd_t cmd;
    logic     rsp_valid;
    logic     rsp_stall;
    spq_rsp_t rsp;

    logic signed [VALUE_W-1:0] model_entries [DEPTH];
    int unsigned               model_count;
    spq_rsp_t                  awaited_responses [$];
    table_row_t                directed_rows [$];
    spq_rsp_t                  want_rsp;
    int unsigned               failures;
    bit                        calm;
    traffic_phase_t            phase;
    int unsigned               phase_left;

    sorted_priority_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Apply one command to the model store and return the response it implies
    function automatic spq_rsp_t sorted_store_update(input spq_cmd_t op);
        spq_rsp_t                  r;
        logic signed [VALUE_W-1:0] v;
        int unsigned               i;
        int unsigned               j;
        r = '0;
        r.status = ST_OK;
        v = op.value;
        case (op.command)
            CMD_INSERT:
            begin
                if (model_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // new value goes ahead of any equal entries
                    i = model_count;
                    while (i > 0 && v >= model_entries[i-1])
                    begin
                        model_entries[i] = model_entries[i-1];
                        i--;
                    end
                    model_entries[i] = v;
                    model_count++;
                end
            end
            CMD_DELETE:
            begin
                if (model_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    i = 0;
                    while (i < model_count && model_entries[i] != v)
                        i++;
                    if (i == model_count)
                        r.status = ST_NOT_FOUND;
                    else
                    begin
                        for (j = i; j + 1 < model_count; j++)
                            model_entries[j] = model_entries[j+1];
                        model_count--;
                    end
                end
            end
            CMD_READ:
            begin
                if (op.position < model_count)
                    r.read_value = model_entries[op.position];
                else
                    r.status = ST_BAD_POS;
            end
            default:
            begin
                // unused code: nothing changes
            end
        endcase
        r.entry_count = COUNT_W'(model_count);
        return r;
    endfunction

    function automatic logic signed [VALUE_W-1:0] draw_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = VALUE_MAX;
            1: v = VALUE_MIN;
            2, 3, 4, 5:
            begin
                // narrow pool so equal entries pile up
                v = $urandom_range(0, 6);
                v = v - 3;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic spq_cmd_t draw_command();
        spq_cmd_t    op;
        int unsigned roll;
        int unsigned ins_w;
        int unsigned del_w;
        int unsigned rd_w;
        op.command = CMD_UNUSED;
        op.value = draw_value();
        op.position = POS_W'($urandom_range(0, 63));
        case (phase)
            PHASE_FILL:
            begin
                ins_w = 70;
                del_w = 10;
                rd_w = 15;
            end
            PHASE_DRAIN:
            begin
                ins_w = 15;
                del_w = 70;
                rd_w = 10;
            end
            default:
            begin
                ins_w = 35;
                del_w = 30;
                rd_w = 30;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_w)
            op.command = CMD_INSERT;
        else if (roll < ins_w + del_w)
        begin
            op.command = CMD_DELETE;
            // aim most deletes at a stored value so they land
            if (model_count != 0 && $urandom_range(0, 6) != 0)
                op.value = model_entries[$urandom_range(0, model_count - 1)];
        end
        else if (roll < ins_w + del_w + rd_w)
        begin
            op.command = CMD_READ;
            if (model_count != 0 && $urandom_range(0, 3) != 0)
                op.position = POS_W'($urandom_range(0, model_count - 1));
        end
        return op;
    endfunction

    task automatic table_row(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v,
                             input logic [POS_W-1:0] p, input bit fixed,
                             input logic [STAT_W-1:0] s, input logic signed [VALUE_W-1:0] rd,
                             input logic [COUNT_W-1:0] n);
        table_row_t row;
        row.op.command = c;
        row.op.value = v;
        row.op.position = p;
        row.fixed = fixed;
        row.rsp.status = s;
        row.rsp.read_value = rd;
        row.rsp.entry_count = n;
        directed_rows.push_back(row);
    endtask

    // Hold the command until it transfers, then log its expected response
    task automatic send_command(input spq_cmd_t op, input bit fixed, input spq_rsp_t fixed_rsp);
        spq_rsp_t predicted;
        cmd <= op;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predicted = sorted_store_update(op);
        awaited_responses.push_back(fixed ? fixed_rsp : predicted);
    endtask

    task automatic sender_idle(input bit flush);
        if (flush)
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while (awaited_responses.size() != 0);
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 19))
                @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        spq_rsp_t    none;
        int unsigned n;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        calm = 1'b0;
        failures = 0;
        model_count = 0;
        none = '0;
        phase = PHASE_FILL;
        phase_left = 4;

        //        command     value      pos fixed status        read_value count
        table_row(CMD_READ,   0,         0,  1, ST_BAD_POS,   0,         0);
        table_row(CMD_DELETE, 5,         0,  1, ST_EMPTY,     0,         0);
        table_row(CMD_UNUSED, -1,        63, 1, ST_OK,        0,         0);
        table_row(CMD_INSERT, VALUE_MAX, 0,  1, ST_OK,        0,         1);
        table_row(CMD_INSERT, VALUE_MIN, 0,  1, ST_OK,        0,         2);
        table_row(CMD_READ,   0,         0,  1, ST_OK,        VALUE_MAX, 2);
        table_row(CMD_READ,   0,         1,  1, ST_OK,        VALUE_MIN, 2);
        table_row(CMD_READ,   0,         2,  1, ST_BAD_POS,   0,         2);
        table_row(CMD_READ,   VALUE_MAX, 63, 1, ST_BAD_POS,   0,         2);
        table_row(CMD_INSERT, 0,         0,  0, ST_OK,        0,         0);
        table_row(CMD_INSERT, 0,         0,  0, ST_OK,        0,         0);
        table_row(CMD_INSERT, -1,        0,  0, ST_OK,        0,         0);
        table_row(CMD_INSERT, 1,         0,  0, ST_OK,        0,         0);
        table_row(CMD_READ,   0,         2,  0, ST_OK,        0,         0);
        table_row(CMD_READ,   0,         5,  0, ST_OK,        0,         0);
        table_row(CMD_DELETE, 0,         0,  0, ST_OK,        0,         0);
        table_row(CMD_DELETE, 12345,     0,  1, ST_NOT_FOUND, 0,         5);
        table_row(CMD_DELETE, VALUE_MIN, 0,  0, ST_OK,        0,         0);
        table_row(CMD_DELETE, VALUE_MAX, 0,  0, ST_OK,        0,         0);
        table_row(CMD_UNUSED, 0,         0,  0, ST_OK,        0,         0);
        table_row(CMD_READ,   0,         0,  0, ST_OK,        0,         0);
        table_row(CMD_DELETE, -1,        0,  0, ST_OK,        0,         0);
        table_row(CMD_DELETE, 1,         0,  0, ST_OK,        0,         0);
        table_row(CMD_DELETE, 0,         0,  0, ST_OK,        0,         0);
        table_row(CMD_DELETE, 0,         0,  1, ST_EMPTY,     0,         0);

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < directed_rows.size(); n++)
        begin
            send_command(directed_rows[n].op, directed_rows[n].fixed, directed_rows[n].rsp);
            sender_idle(n == directed_rows.size() - 1);
        end

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            send_command(draw_command(), 1'b0, none);
            // fill and drain phases run a few items past full or empty
            if (phase == PHASE_MIXED || model_count == (phase == PHASE_FILL ? DEPTH : 0))
            begin
                if (phase_left != 0)
                    phase_left--;
                else if (phase != PHASE_MIXED)
                begin
                    phase = PHASE_MIXED;
                    phase_left = $urandom_range(20, 60);
                end
                else
                begin
                    phase = (model_count < DEPTH / 2) ? PHASE_FILL : PHASE_DRAIN;
                    phase_left = $urandom_range(2, 6);
                end
            end
            sender_idle(n == RANDOM_ITEMS / 2);
        end
        cmd_valid <= 1'b0;

        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (failures == 0)
            $display("sorted_priority_queue regression: pass");
        else
            $display("sorted_priority_queue regression: fail");
        $finish;
    end

    // Response side: stall in bursts, none once the run turns calm
    initial
    begin
        rsp_stall = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            repeat ($urandom_range(1, 40))
                @(posedge clk);
            if (!calm && $urandom_range(0, 1) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 19))
                    @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_responses.size() == 0)
            begin
                $error("response transfer with no command outstanding");
                failures++;
            end
            else
            begin
                want_rsp = awaited_responses.pop_front();
                if (rsp.status !== want_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
                    failures++;
                end
                if (rsp.read_value !== want_rsp.read_value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           want_rsp.read_value, rsp.read_value);
                    failures++;
                end
                if (rsp.entry_count !== want_rsp.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want_rsp.entry_count, rsp.entry_count);
                    failures++;
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("sorted_priority_queue regression: fail");
        $finish;
    end

endmodule
